@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion clocked on the rising edge and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/intsq_pkg.sv @@
`default_nettype none
package intsq_pkg;

   // Largest supported frame geometry.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Fixed field widths.
   localparam int PIX_W   = 8;
   localparam int CFG_W   = 11;
   localparam int SUM_W   = 28;   // area sum and its line entry
   localparam int SQO_W   = 36;   // area square sum on the result
   localparam int SQL_W   = 37;   // square line entry
   localparam int LINE_W  = SUM_W + SQL_W;
   localparam int PSQ_W   = 2 * PIX_W;

   // Counter and running-sum widths follow the maximum geometry.
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int RSUM_W  = $clog2(MAX_WIDTH * 255 + 1);
   localparam int RSQ_W   = $clog2(MAX_WIDTH * 65025 + 1);
   localparam int WCMP_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int HCMP_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

   // Register file.
   localparam int CSR_IDX_W = 1;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   // Pixel in flight between the line-store read and the write-back.
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [RSUM_W-1:0] run_sum;
      logic [RSQ_W-1:0]  run_sq;
      logic              use_above;
      logic              row_end;
      logic              frame_end;
   } stage_type;

endpackage
`default_nettype wire

@@ rtl/core/intsq_ram.sv @@
`default_nettype none
module intsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/integral_and_square_image_core.sv @@
`default_nettype none
`include "assert_macros.svh"
// Integral image and squared integral image of an 8-bit gray pixel stream in
// raster order. Each request carries one pixel; each response carries the sum
// of all pixels from the frame origin to that pixel (inclusive) and the sum of
// their squares, with row_end on rsp_tuser and frame_end on rsp_tlast. Frame
// geometry comes from two registers (index 0 frame_width, index 1
// frame_height; 0 acts as 1, values above the maximum clamp to it); write them
// only while no request is in flight. A change mid-frame takes effect on the
// next request: a column or row counter at or beyond the new last position
// ends its row or frame at once. Throughput is one pixel per clock unless
// rsp_tready stalls: a single line RAM holding the previous row's totals is
// read at the pixel's column in the accept cycle and written back as the pixel
// leaves stage 1; its one read and one write port per cycle set the rate. A
// response passes stage 1 and the output register. The line RAM needs no
// clearing pass after reset: the first row of every frame ignores it.
module integral_and_square_image_core
   import intsq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] pixel
   // response channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [63:0]               rsp_tdata,   // [27:0] area_sum, [63:28] area_square_sum
   output logic                      rsp_tuser,   // [0] row_end
   output logic                      rsp_tlast,   // frame_end
   // configuration
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] frame_width_ff,  frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Clamp the geometry: zero acts as one, oversize acts as the maximum.
   logic [WCMP_W-1:0] width_eff;
   logic [HCMP_W-1:0] height_eff;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WCMP_W'(1);
      end else if (WCMP_W'(frame_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = WCMP_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = HCMP_W'(1);
      end else if (HCMP_W'(frame_height_ff) > HCMP_W'(MAX_HEIGHT)) begin
         height_eff = HCMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = HCMP_W'(frame_height_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: stage 1 holds the pixel waiting on its line-RAM data, the
   // output register holds the finished response.
   // ---------------------------------------------------------------------
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      out_valid_ff, out_valid_in;
   logic      s1_go;
   logic      req_accept;

   // Stage 1 moves on when the output register is free or being drained.
   assign s1_go      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   // Take a new request only when stage 1 frees up, so the RAM read data
   // for the waiting pixel is never overwritten.
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // Stage 0: counters, running row sums, line-RAM read
   // ---------------------------------------------------------------------
   logic [COL_W-1:0]  col_cnt_ff,  col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff,  row_cnt_in;
   logic [RSUM_W-1:0] run_sum_ff,  run_sum_in;
   logic [RSQ_W-1:0]  run_sq_ff,   run_sq_in;
   logic [PIX_W-1:0]  pixel;
   logic [PSQ_W-1:0]  pixel_sq;
   logic [RSUM_W-1:0] sum_now;
   logic [RSQ_W-1:0]  sq_now;
   logic              last_col;
   logic              last_row;

   assign pixel    = req_tdata[PIX_W-1:0];
   assign pixel_sq = PSQ_W'(pixel) * PSQ_W'(pixel);
   assign sum_now  = run_sum_ff + RSUM_W'(pixel);
   assign sq_now   = run_sq_ff + RSQ_W'(pixel_sq);
   assign last_col = (WCMP_W'(col_cnt_ff) + WCMP_W'(1)) >= width_eff;
   assign last_row = (HCMP_W'(row_cnt_ff) + HCMP_W'(1)) >= height_eff;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      run_sum_in = run_sum_ff;
      run_sq_in  = run_sq_ff;
      if (req_accept) begin
         if (last_col) begin
            // Close the row: restart the column and the running sums.
            col_cnt_in = '0;
            run_sum_in = '0;
            run_sq_in  = '0;
            row_cnt_in = last_row ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
            run_sum_in = sum_now;
            run_sq_in  = sq_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         run_sum_ff <= '0;
         run_sq_ff  <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         run_sum_ff <= run_sum_in;
         run_sq_ff  <= run_sq_in;
      end
   end

   always_comb begin
      s1_in.col       = col_cnt_ff;
      s1_in.run_sum   = sum_now;
      s1_in.run_sq    = sq_now;
      s1_in.use_above = (row_cnt_ff != '0);
      s1_in.row_end   = last_col;
      s1_in.frame_end = last_col && last_row;
   end

   assign s1_valid_in = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line RAM: previous row totals, {square, sum} per column
   // ---------------------------------------------------------------------
   logic [LINE_W-1:0] line_rd_data;
   logic [LINE_W-1:0] line_wr_data;
   logic [SUM_W-1:0]  total_sum;
   logic [SQL_W-1:0]  total_sq;

   assign line_wr_data = {total_sq, total_sum};

   intsq_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_cnt_ff),
      .rd_data (line_rd_data)
   );

   // Forward the write-back when it hits the column being read in the same
   // cycle (narrow frames, where a column is revisited on the next pixel).
   logic              fwd_hit_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_hit_ff <= s1_go && (s1_ff.col == col_cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_data_ff <= line_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: add the row above, write back, load the response
   // ---------------------------------------------------------------------
   logic [LINE_W-1:0] above_word;
   logic [SUM_W-1:0]  above_sum;
   logic [SQL_W-1:0]  above_sq;

   always_comb begin
      above_word = fwd_hit_ff ? fwd_data_ff : line_rd_data;
      if (s1_ff.use_above) begin
         above_sum = above_word[SUM_W-1:0];
         above_sq  = above_word[LINE_W-1:SUM_W];
      end else begin
         // First row of the frame: nothing above.
         above_sum = '0;
         above_sq  = '0;
      end
      total_sum = above_sum + SUM_W'(s1_ff.run_sum);
      total_sq  = above_sq + SQL_W'(s1_ff.run_sq);
   end

   logic [SUM_W-1:0] out_sum_ff;
   logic [SQO_W-1:0] out_sq_ff;
   logic             out_row_end_ff;
   logic             out_frame_end_ff;

   assign out_valid_in = s1_go ? 1'b1 : ((out_valid_ff && rsp_tready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_sum_ff       <= total_sum;
         out_sq_ff        <= total_sq[SQO_W-1:0];
         out_row_end_ff   <= s1_ff.row_end;
         out_frame_end_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_sq_ff, out_sum_ff};
   assign rsp_tuser  = out_row_end_ff;
   assign rsp_tlast  = out_frame_end_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Stage 0 state as it stands right after a row closes.
   logic row_restarted;
   assign row_restarted = (col_cnt_ff == '0) && (run_sum_ff == '0) && (run_sq_ff == '0);

   // An accepted request always lands in stage 1.
   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff)
   // A frame end is always also a row end.
   `ASSERT_SAME(a_frame_end_is_row_end, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   // Closing a row restarts the column and both running sums.
   `ASSERT_NEXT(a_row_close_restarts, clock, reset, req_accept && last_col, row_restarted)

endmodule
`default_nettype wire
